FILE: design/dmchc_pkg.sv
package dmchc_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_LINES  = 16384;
    localparam int DEF_ADDR_WIDTH = 32;

    // Widths fixed by the beat format.
    localparam int ADDR_IN_W = 32;
    localparam int CNT_W     = 32;
    localparam int OFF_W     = 5;
    localparam int IXB_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 1'd1;

    // Register reset values.
    localparam logic [OFF_W-1:0] RST_OFFSET_BITS = 5'd4;
    localparam logic [IXB_W-1:0] RST_INDEX_BITS  = 4'd6;

    // Saturation value of both counters.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Address geometry as currently configured.
    typedef struct packed {
        logic [OFF_W-1:0] offset_bits;
        logic [IXB_W-1:0] index_bits;
    } t_cfg;

endpackage

FILE: design/dmchc_tag_ram.sv
module dmchc_tag_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // One write port; a read in the same cycle as a write returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: design/dmchc_addr_split.sv
module dmchc_addr_split #(
    parameter int MAX_LINES  = 16384,
    parameter int ADDR_WIDTH = 32,
    parameter int IDX_W      = 14,
    parameter int TAG_W      = 32
) (
    input  logic [dmchc_pkg::ADDR_IN_W-1:0] i_address,
    input  dmchc_pkg::t_cfg                 i_cfg,
    output logic [IDX_W-1:0]                o_line,
    output logic [TAG_W-1:0]                o_tag
);
    import dmchc_pkg::*;

    // Widest index that still addresses an existing line.
    localparam int LIM   = $clog2(MAX_LINES + 1) - 1;
    localparam int IWC_W = 5;
    localparam int SH_W  = 6;

    logic [TAG_W-1:0] addr_m;
    logic [63:0]      addr_ext;
    logic [63:0]      shifted;
    logic [IWC_W-1:0] iw_c;
    logic [IDX_W-1:0] line_mask;
    logic [SH_W-1:0]  tag_shift;

    // Keep only the implemented address bits.
    assign addr_m   = i_address[TAG_W-1:0];
    assign addr_ext = 64'(addr_m);

    // Clamp the index width to what the line store can hold.
    assign iw_c = (IWC_W'(i_cfg.index_bits) > IWC_W'(LIM)) ? IWC_W'(LIM)
                                                            : IWC_W'(i_cfg.index_bits);

    // Line number sits just above the offset bits.
    assign shifted   = addr_ext >> i_cfg.offset_bits;
    assign line_mask = ~({IDX_W{1'b1}} << iw_c);
    assign o_line    = shifted[IDX_W-1:0] & line_mask;

    // The tag is everything above the line number; bits past the address read as zero.
    assign tag_shift = SH_W'(i_cfg.offset_bits) + SH_W'(iw_c);
    assign o_tag     = TAG_W'(addr_ext >> tag_shift);

endmodule

FILE: design/direct_mapped_cache_hit_counter.sv
// Direct-mapped cache tag store with hit and access counting.
// Each beat on the s_axis channel carries one 32-bit byte address. The block
// splits it into offset, line number and tag, looks the line up in an on-chip
// tag memory and, on a miss, fills the line with the new tag. Every address
// gives one beat on m_axis: the hit flag in tuser and the saturating hit and
// access counts, both including this access, in tdata.
// Geometry is set through the write port i_cfg_*: index 0 is the number of
// offset bits, index 1 the number of index bits. Write it only while idle.
// An accepted address passes the lookup stage, then the output register, to m_axis.
// Throughput is one address per cycle unless the clearing pass or a stalled
// receiver holds the flow: the tag memory is read in the accept cycle and
// written back when the lookup completes, and an address that follows on the
// same line takes its tag from a forwarding register. After reset a clearing
// pass writes every line invalid, one line a cycle; s_axis_tready stays low
// until it ends. Configuration writes are taken during the pass.
// When the receiver stalls, the result waits in the output register, the
// lookup stage holds and s_axis_tready drops once it is full; nothing is lost.
module direct_mapped_cache_hit_counter #(
    parameter int MAX_LINES  = dmchc_pkg::DEF_MAX_LINES,
    parameter int ADDR_WIDTH = dmchc_pkg::DEF_ADDR_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [dmchc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmchc_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    // Address input.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [31:0] address
    // Result output.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // [31:0] hit_count, [63:32] access_count
    output logic                            m_axis_tuser   // [0] hit
);
    import dmchc_pkg::*;

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int TAG_W = (ADDR_WIDTH < ADDR_IN_W) ? ADDR_WIDTH : ADDR_IN_W;
    localparam int ENT_W = TAG_W + 1;

    t_cfg             r_cfg;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_cnt;
    logic             r_s1_vld;
    logic [IDX_W-1:0] r_s1_line;
    logic [TAG_W-1:0] r_s1_tag;
    logic             r_s1_fwd;
    logic [TAG_W-1:0] r_s1_fwd_tag;
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_accs;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_accs;
    logic             r_out_vld;
    logic             r_out_hit;
    logic [CNT_W-1:0] r_out_hits;
    logic [CNT_W-1:0] r_out_accs;

    logic             s_fire;
    logic             out_free;
    logic             s1_fire;
    logic [IDX_W-1:0] in_line;
    logic [TAG_W-1:0] in_tag;
    logic [ENT_W-1:0] ram_rdata;
    logic             ent_valid;
    logic [TAG_W-1:0] ent_tag;
    logic             hit;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;

    // Handshake control.
    assign out_free      = !r_out_vld || m_axis_tready;
    assign s1_fire       = r_s1_vld && out_free;
    assign s_axis_tready = !r_clr_busy && (!r_s1_vld || out_free);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Configuration registers; unknown indices are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_bits <= RST_OFFSET_BITS;
            r_cfg.index_bits  <= RST_INDEX_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_wdata[OFF_W-1:0];
                REG_INDEX_BITS:  r_cfg.index_bits  <= i_cfg_wdata[IXB_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing pass over the tag memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == IDX_W'(MAX_LINES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Address decode in the accept cycle.
    dmchc_addr_split #(
        .MAX_LINES  (MAX_LINES),
        .ADDR_WIDTH (ADDR_WIDTH),
        .IDX_W      (IDX_W),
        .TAG_W      (TAG_W)
    ) u_split (
        .i_address (s_axis_tdata),
        .i_cfg     (r_cfg),
        .o_line    (in_line),
        .o_tag     (in_tag)
    );

    // Memory write: the clearing pass first, then miss fills.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_s1_line;
        ram_wdata = {1'b1, r_s1_tag};
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else if (s1_fire && !hit) begin
            ram_we = 1'b1;
        end
    end

    dmchc_tag_ram #(
        .DEPTH  (MAX_LINES),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s_fire),
        .i_raddr (in_line),
        .o_rdata (ram_rdata)
    );

    // Lookup stage. A read issued while the previous beat writes the same line
    // sees stale data, so that beat's tag is forwarded instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1_line    <= in_line;
            r_s1_tag     <= in_tag;
            r_s1_fwd     <= s1_fire && (r_s1_line == in_line);
            r_s1_fwd_tag <= r_s1_tag;
        end
    end

    assign ent_valid = r_s1_fwd || ram_rdata[TAG_W];
    assign ent_tag   = r_s1_fwd ? r_s1_fwd_tag : ram_rdata[TAG_W-1:0];
    assign hit       = ent_valid && (ent_tag == r_s1_tag);

    // Saturating counters.
    always_comb begin
        n_hits = r_hits;
        n_accs = r_accs;
        if (hit && r_hits != CNT_MAX) begin
            n_hits = r_hits + 1'b1;
        end
        if (r_accs != CNT_MAX) begin
            n_accs = r_accs + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_accs <= '0;
        end else if (s1_fire) begin
            r_hits <= n_hits;
            r_accs <= n_accs;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_hit  <= hit;
            r_out_hits <= n_hits;
            r_out_accs <= n_accs;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_accs, r_out_hits};
    assign m_axis_tuser  = r_out_hit;

    // The lookup stage stays empty while the memory is being cleared.
    a_no_lookup_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_vld)
        else $error("lookup stage busy during clearing pass");

    // Every completed lookup advances the access count by one unless saturated.
    a_acc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_accs == $past(r_accs) + 1'b1) || ($past(r_accs) == CNT_MAX))
        else $error("access count did not advance");

    // Hits can never outnumber accesses.
    a_hits_le_accs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_hits <= r_out_accs))
        else $error("hit count above access count");

    // A reported hit implies a non-zero hit count.
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_hit) |-> (r_out_hits != '0))
        else $error("hit reported with zero hit count");

endmodule
